// ===== src/bfea_pkg.sv =====
// Shared types and codes for the best-fit extent allocator.
package bfea_pkg;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] req_size;
    logic [31:0] addr;
  } req_t;

  typedef struct packed {
    logic [31:0] block_addr;
    logic [2:0]  status;
    logic [31:0] free_bytes;
  } rsp_t;

  localparam logic [1:0] FUNC_BEST = 2'd0;
  localparam logic [1:0] FUNC_AT   = 2'd1;
  localparam logic [1:0] FUNC_FREE = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_OUTSIDE = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_HINT    = 3'd4;

  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_SIZE  = 2'd1;
  localparam logic [1:0] REG_ROUND = 2'd2;

  localparam logic [31:0] RST_BASE  = 32'd0;
  localparam logic [31:0] RST_SIZE  = 32'd65536;
  localparam logic [8:0]  RST_ROUND = 9'd8;

endpackage

// ===== src/best_fit_extent_allocator.sv =====
// Top level of the best-fit extent allocator.
//
// Requests enter on start/req_i when busy is low: func selects best-fit
// allocate, allocate at hint, or free. Exactly one result per request appears
// on result_o, marked by done_o for one cycle; the receiver cannot stall it.
// The free extents are kept in one RAM ordered by address (start, length).
// A request passes through the bit-serial rounding unit, a check, a scan that
// streams the table through the RAM read port, a decision and a finish step.
// Removing or inserting an extent first moves the tail entries one slot
// through the single RAM write port; an insert then writes the new extent.
// busy falls as the result shows, so the next request is accepted at the
// earliest at the edge that ends the result cycle.
// After reset, and after a write to the base, size or rounding register on
// the APB port, the table is re-initialized to one extent covering the whole
// region (none if the size is zero), during which busy is high. Register
// writes must be made while idle; the block itself does not enforce this.
module best_fit_extent_allocator #(
  parameter int MAX_EXTENTS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  bfea_pkg::req_t       req_i,
  output logic                 done_o,
  output bfea_pkg::rsp_t       result_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import bfea_pkg::*;

  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_EXTENTS);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_ROUND  = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_DECIDE = 4'd5;
  localparam logic [3:0] S_SHIFT  = 4'd6;
  localparam logic [3:0] S_INSNEW = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  logic [3:0]    state_q, state_d;
  logic [31:0]   base_q, base_d, rsize_q, rsize_d, free_q, free_d;
  logic [8:0]    unit_q, unit_d;
  logic [CW-1:0] cnt_q, cnt_d, k_q, k_d, ptr_q, ptr_d, mv_q, mv_d, rk_q, rk_d;
  logic          rv_q, rv_d, found_q, found_d, ins_q, ins_d, done_q, done_d;
  logic [1:0]    func_q, func_d;
  logic [31:0]   addr_q, addr_d, est_q, est_d, eln_q, eln_d, pst_q, pst_d;
  logic [31:0]   pln_q, pln_d, res_addr_q, res_addr_d;
  logic [2:0]    res_st_q, res_st_d;
  logic [32:0]   size_q, size_d;
  logic [63:0]   nv_q, nv_d;
  logic [IW-1:0] nk_q, nk_d;
  rsp_t          rsp_q, rsp_d;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [63:0]   wdata, rdata;
  logic          rnd_start, rnd_done;
  logic [32:0]   rnd_size;
  logic          cfg_wr;

  logic [31:0]   rd_st, rd_ln;
  logic [32:0]   rd_end, ext_end, rend, pe, e_f, fl;
  logic [33:0]   he;
  logic [CW-1:0] pos;
  logic          bad, jp, jn;

  bfea_ram #(.WIDTH(64), .DEPTH(MAX_EXTENTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  bfea_round u_round (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rnd_start),
    .req_size_i (req_i.req_size),
    .unit_i     (unit_q),
    .done_o     (rnd_done),
    .size_o     (rnd_size)
  );

  assign busy      = (state_q != S_IDLE);
  assign rnd_start = start && !busy;
  assign cfg_wr    = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_BASE:  prdata = base_q;
      REG_SIZE:  prdata = rsize_q;
      REG_ROUND: prdata = {23'd0, unit_q};
      default:   prdata = 32'd0;
    endcase
  end

  assign rd_st   = rdata[63:32];
  assign rd_ln   = rdata[31:0];
  assign rd_end  = {1'b0, rd_st} + {1'b0, rd_ln};
  assign ext_end = {1'b0, est_q} + {1'b0, eln_q};
  assign he      = {2'b0, addr_q} + {1'b0, size_q};
  assign rend    = {1'b0, base_q} + {1'b0, rsize_q};
  assign pe      = {1'b0, pst_q} + {1'b0, pln_q};
  assign e_f     = (he > {1'b0, rend}) ? rend : he[32:0];
  assign fl      = e_f - {1'b0, addr_q};
  assign pos     = found_q ? k_q : cnt_q;
  assign jp      = (pos != '0) && (pe == {1'b0, addr_q});
  assign jn      = found_q && ({1'b0, est_q} == e_f);
  assign bad     = ((pos != '0) && (pe > {1'b0, addr_q})) ||
                   (found_q && ({1'b0, est_q} < e_f));

  always_comb begin
    state_d    = state_q;
    base_d     = base_q;
    rsize_d    = rsize_q;
    unit_d     = unit_q;
    cnt_d      = cnt_q;
    free_d     = free_q;
    k_d        = k_q;
    ptr_d      = ptr_q;
    mv_d       = mv_q;
    rk_d       = rk_q;
    rv_d       = 1'b0;
    found_d    = found_q;
    ins_d      = ins_q;
    done_d     = 1'b0;
    func_d     = func_q;
    addr_d     = addr_q;
    est_d      = est_q;
    eln_d      = eln_q;
    pst_d      = pst_q;
    pln_d      = pln_q;
    res_addr_d = res_addr_q;
    res_st_d   = res_st_q;
    size_d     = size_q;
    nv_d       = nv_q;
    nk_d       = nk_q;
    rsp_d      = rsp_q;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    raddr      = ptr_q[IW-1:0];

    case (state_q)
      S_INIT: begin
        we      = 1'b1;
        wdata   = {base_q, rsize_q};
        cnt_d   = (rsize_q != 32'd0) ? CW'(1) : '0;
        free_d  = rsize_q;
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          func_d   = req_i.func;
          addr_d   = req_i.addr;
          res_addr_d = 32'd0;
          res_st_d = ST_OK;
          state_d  = S_ROUND;
        end
      end
      S_ROUND: begin
        if (rnd_done) begin
          size_d  = rnd_size;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        ptr_d   = '0;
        found_d = 1'b0;
        state_d = S_SCAN;
        case (func_q)
          FUNC_BEST: begin
            if ({1'b0, free_q} < size_q) begin
              res_st_d = ST_NOFIT;
              state_d  = S_FIN;
            end
          end
          FUNC_AT: ;
          FUNC_FREE: begin
            if ((addr_q < base_q) || ({1'b0, addr_q} >= rend)) begin
              res_st_d = ST_OUTSIDE;
              state_d  = S_FIN;
            end
          end
          default: state_d = S_FIN;
        endcase
      end
      S_SCAN: begin
        // stream the table: issue one read, evaluate the one issued last cycle
        if (ptr_q != cnt_q) begin
          rv_d  = 1'b1;
          rk_d  = ptr_q;
          ptr_d = ptr_q + CW'(1);
        end
        if (rv_q) begin
          case (func_q)
            FUNC_BEST: begin
              if (({1'b0, rd_ln} >= size_q) && (!found_q || rd_ln < eln_q)) begin
                found_d = 1'b1;
                k_d     = rk_q;
                est_d   = rd_st;
                eln_d   = rd_ln;
              end
            end
            FUNC_AT: begin
              if (!found_q && (addr_q >= rd_st) && (he <= {1'b0, rd_end})) begin
                found_d = 1'b1;
                k_d     = rk_q;
                est_d   = rd_st;
                eln_d   = rd_ln;
              end
            end
            default: begin
              if (!found_q) begin
                if (rd_st >= addr_q) begin
                  found_d = 1'b1;
                  k_d     = rk_q;
                  est_d   = rd_st;
                  eln_d   = rd_ln;
                end else begin
                  pst_d = rd_st;
                  pln_d = rd_ln;
                end
              end
            end
          endcase
        end
        if ((ptr_q == cnt_q) && !rv_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_FIN;
        case (func_q)
          FUNC_BEST: begin
            if (!found_q) begin
              res_st_d = ST_NOFIT;
            end else begin
              res_addr_d = est_q;
              free_d     = free_q - size_q[31:0];
              if ({1'b0, eln_q} == size_q) begin
                ins_d   = 1'b0;
                mv_d    = cnt_q - CW'(1) - k_q;
                ptr_d   = k_q + CW'(1);
                cnt_d   = cnt_q - CW'(1);
                state_d = S_SHIFT;
              end else begin
                we    = 1'b1;
                waddr = k_q[IW-1:0];
                wdata = {est_q + size_q[31:0], eln_q - size_q[31:0]};
              end
            end
          end
          FUNC_AT: begin
            if (!found_q) begin
              res_st_d = ST_HINT;
            end else if ((addr_q != est_q) && (he != {1'b0, ext_end}) &&
                         (cnt_q == CNT_MAX)) begin
              res_st_d = ST_FULL;
            end else begin
              res_addr_d = addr_q;
              free_d     = free_q - size_q[31:0];
              if ((addr_q == est_q) && (he == {1'b0, ext_end})) begin
                ins_d   = 1'b0;
                mv_d    = cnt_q - CW'(1) - k_q;
                ptr_d   = k_q + CW'(1);
                cnt_d   = cnt_q - CW'(1);
                state_d = S_SHIFT;
              end else if (addr_q == est_q) begin
                we    = 1'b1;
                waddr = k_q[IW-1:0];
                wdata = {he[31:0], ext_end[31:0] - he[31:0]};
              end else begin
                we    = 1'b1;
                waddr = k_q[IW-1:0];
                wdata = {est_q, addr_q - est_q};
                if (he != {1'b0, ext_end}) begin
                  // split: tail part goes into a new slot after this one
                  ins_d   = 1'b1;
                  nk_d    = k_q[IW-1:0] + IW'(1);
                  nv_d    = {he[31:0], ext_end[31:0] - he[31:0]};
                  mv_d    = cnt_q - k_q - CW'(1);
                  ptr_d   = cnt_q - CW'(1);
                  cnt_d   = cnt_q + CW'(1);
                  state_d = S_SHIFT;
                end
              end
            end
          end
          default: begin
            if (bad) begin
              res_st_d = ST_OUTSIDE;
            end else if (!jp && !jn && (cnt_q == CNT_MAX)) begin
              res_st_d = ST_FULL;
            end else begin
              free_d = free_q + fl[31:0];
              if (jp) begin
                we    = 1'b1;
                waddr = pos[IW-1:0] - IW'(1);
                wdata = {pst_q, pln_q + fl[31:0] + (jn ? eln_q : 32'd0)};
                if (jn) begin
                  ins_d   = 1'b0;
                  mv_d    = cnt_q - CW'(1) - pos;
                  ptr_d   = pos + CW'(1);
                  cnt_d   = cnt_q - CW'(1);
                  state_d = S_SHIFT;
                end
              end else if (jn) begin
                we    = 1'b1;
                waddr = pos[IW-1:0];
                wdata = {addr_q, eln_q + fl[31:0]};
              end else begin
                ins_d   = 1'b1;
                nk_d    = pos[IW-1:0];
                nv_d    = {addr_q, fl[31:0]};
                mv_d    = cnt_q - pos;
                ptr_d   = cnt_q - CW'(1);
                cnt_d   = cnt_q + CW'(1);
                state_d = S_SHIFT;
              end
            end
          end
        endcase
      end
      S_SHIFT: begin
        // move the tail one slot: read ahead, write the entry read last cycle
        if (mv_q != '0) begin
          rv_d  = 1'b1;
          rk_d  = ptr_q;
          ptr_d = ins_q ? ptr_q - CW'(1) : ptr_q + CW'(1);
          mv_d  = mv_q - CW'(1);
        end
        if (rv_q) begin
          we    = 1'b1;
          waddr = ins_q ? rk_q[IW-1:0] + IW'(1) : rk_q[IW-1:0] - IW'(1);
          wdata = rdata;
        end
        if ((mv_q == '0) && !rv_q) begin
          state_d = ins_q ? S_INSNEW : S_FIN;
        end
      end
      S_INSNEW: begin
        we      = 1'b1;
        waddr   = nk_q;
        wdata   = nv_q;
        state_d = S_FIN;
      end
      S_FIN: begin
        done_d           = 1'b1;
        rsp_d.block_addr = (res_st_q == ST_OK) ? res_addr_q : 32'd0;
        rsp_d.status     = res_st_q;
        rsp_d.free_bytes = free_q;
        state_d          = S_IDLE;
      end
      default: state_d = S_INIT;
    endcase

    if (cfg_wr) begin
      case (paddr[3:2])
        REG_BASE:  begin base_d  = pwdata;      state_d = S_INIT; end
        REG_SIZE:  begin rsize_d = pwdata;      state_d = S_INIT; end
        REG_ROUND: begin unit_d  = pwdata[8:0]; state_d = S_INIT; end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      base_q  <= RST_BASE;
      rsize_q <= RST_SIZE;
      unit_q  <= RST_ROUND;
      cnt_q   <= '0;
      free_q  <= '0;
      rv_q    <= 1'b0;
      done_q  <= 1'b0;
      mv_q    <= '0;
      ptr_q   <= '0;
      found_q <= 1'b0;
      ins_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      rsize_q <= rsize_d;
      unit_q  <= unit_d;
      cnt_q   <= cnt_d;
      free_q  <= free_d;
      rv_q    <= rv_d;
      done_q  <= done_d;
      mv_q    <= mv_d;
      ptr_q   <= ptr_d;
      found_q <= found_d;
      ins_q   <= ins_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    rk_q       <= rk_d;
    func_q     <= func_d;
    addr_q     <= addr_d;
    est_q      <= est_d;
    eln_q      <= eln_d;
    pst_q      <= pst_d;
    pln_q      <= pln_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
    size_q     <= size_d;
    nv_q       <= nv_d;
    nk_q       <= nk_d;
    rsp_q      <= rsp_d;
  end

  assign done_o   = done_q;
  assign result_o = rsp_q;
endmodule

// ===== src/bfea_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bfea_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== src/bfea_round.sv =====
// Bit-serial size rounding: zero to one, then up to a multiple of the unit.
module bfea_round (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] req_size_i,
  input  logic [8:0]  unit_i,
  output logic        done_o,
  output logic [32:0] size_o
);
  logic        run_q, run_d, done_q, done_d;
  logic [4:0]  bit_q, bit_d;
  logic [31:0] s_q, s_d;
  logic [8:0]  rem_q, rem_d, unit_q, unit_d;
  logic [32:0] size_q, size_d;
  logic [9:0]  rem_x;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    bit_d  = bit_q;
    s_d    = s_q;
    rem_d  = rem_q;
    unit_d = unit_q;
    size_d = size_q;
    rem_x  = {rem_q, s_q[bit_q]};
    if (start_i) begin
      s_d    = (req_size_i == 32'd0) ? 32'd1 : req_size_i;
      unit_d = (unit_i == 9'd0) ? 9'd1 : unit_i;
      rem_d  = '0;
      bit_d  = 5'd31;
      run_d  = 1'b1;
    end else if (run_q) begin
      // long division remainder, one dividend bit per cycle
      if (rem_x >= {1'b0, unit_q}) begin
        rem_x = rem_x - {1'b0, unit_q};
      end
      rem_d = rem_x[8:0];
      bit_d = bit_q - 5'd1;
      if (bit_q == 5'd0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
        size_d = {1'b0, s_q} + ((rem_d != 9'd0) ? {24'd0, unit_q - rem_d} : 33'd0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q  <= bit_d;
    s_q    <= s_d;
    rem_q  <= rem_d;
    unit_q <= unit_d;
    size_q <= size_d;
  end

  assign done_o = done_q;
  assign size_o = size_q;
endmodule

// ===== dv/tb_best_fit_extent_allocator.sv =====
// Self-checking testbench for the best-fit extent allocator, with its own free-extent table model.
module tb_best_fit_extent_allocator;
  import bfea_pkg::*;

  localparam int NEXT     = 32;
  localparam int WDOG_MAX = 5000;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] req_size;
    logic [31:0] addr;
    logic        typed;
    logic [31:0] e_addr;
    logic [2:0]  e_status;
    logic [31:0] e_free;
  } dir_row_t;

  typedef struct {
    logic [31:0] addr;
    logic [31:0] len;
  } held_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        req_i = '0;
  logic        done_o;
  rsp_t        result_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  best_fit_extent_allocator #(.MAX_EXTENTS(NEXT)) i_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // model of the free-extent table
  logic [31:0] cfg_base = RST_BASE, cfg_size = RST_SIZE;
  logic [8:0]  cfg_round = RST_ROUND;
  logic [31:0] ext_start [NEXT];
  logic [31:0] ext_len [NEXT];
  int          ext_cnt;
  logic [31:0] free_left;

  rsp_t  rsp_q [$];
  held_t held_q [$];
  int    accept_cnt = 0, result_cnt = 0, err_cnt = 0, wdog = 0;
  int    status_cnt [8];
  logic  typed_pending = 1'b0;
  rsp_t  typed_rsp;

  dir_row_t dir_tab [14] = '{
    '{FUNC_BEST, 32'd0,          32'd0,          1'b1, 32'd0,   ST_OK,      32'd65528},
    '{FUNC_BEST, 32'hFFFFFFFF,   32'd0,          1'b1, 32'd0,   ST_NOFIT,   32'd65528},
    '{FUNC_AT,   32'd8,          32'hFFFFFFF0,   1'b1, 32'd0,   ST_HINT,    32'd65528},
    '{FUNC_FREE, 32'd8,          32'hFFFFFFFF,   1'b1, 32'd0,   ST_OUTSIDE, 32'd65528},
    '{2'd3,      32'hFFFFFFFF,   32'hFFFFFFFF,   1'b1, 32'd0,   ST_OK,      32'd65528},
    '{FUNC_FREE, 32'd8,          32'd0,          1'b1, 32'd0,   ST_OK,      32'd65536},
    '{FUNC_FREE, 32'd8,          32'd0,          1'b1, 32'd0,   ST_OUTSIDE, 32'd65536},
    '{FUNC_AT,   32'd20,         32'd100,        1'b1, 32'd100, ST_OK,      32'd65512},
    '{FUNC_AT,   32'd100,        32'd0,          1'b1, 32'd0,   ST_HINT,    32'd65512},
    '{FUNC_BEST, 32'd1,          32'd0,          1'b0, 32'd0,   ST_OK,      32'd0},
    '{FUNC_AT,   32'd8,          32'd65528,      1'b0, 32'd0,   ST_OK,      32'd0},
    '{FUNC_FREE, 32'd1000,       32'd65528,      1'b0, 32'd0,   ST_OK,      32'd0},
    '{FUNC_FREE, 32'd24,         32'd100,        1'b0, 32'd0,   ST_OK,      32'd0},
    '{FUNC_BEST, 32'hFFFF0000,   32'd0,          1'b0, 32'd0,   ST_OK,      32'd0}
  };

  function automatic void table_init();
    for (int k = 0; k < NEXT; k++) begin
      ext_start[k] = '0;
      ext_len[k]   = '0;
    end
    ext_cnt = 0;
    if (cfg_size != 0) begin
      ext_start[0] = cfg_base;
      ext_len[0]   = cfg_size;
      ext_cnt      = 1;
    end
    free_left = cfg_size;
  endfunction

  function automatic void ext_remove(int idx);
    for (int k = idx; k < ext_cnt - 1; k++) begin
      ext_start[k] = ext_start[k+1];
      ext_len[k]   = ext_len[k+1];
    end
    ext_cnt--;
    ext_start[ext_cnt] = '0;
    ext_len[ext_cnt]   = '0;
  endfunction

  function automatic void ext_insert(int idx, logic [31:0] s, logic [31:0] l);
    for (int k = ext_cnt; k > idx; k--) begin
      ext_start[k] = ext_start[k-1];
      ext_len[k]   = ext_len[k-1];
    end
    ext_start[idx] = s;
    ext_len[idx]   = l;
    ext_cnt++;
  endfunction

  // Apply one transaction to the table and return the response it should give.
  function automatic rsp_t alloc_predict(req_t r);
    longint unsigned rr, sz, s, e, he, rend, a, pe;
    int          i, best, pos;
    bit          found, jp, jn;
    logic [2:0]  st;
    logic [31:0] blk;
    rsp_t        o;
    rr = (cfg_round == 0) ? 1 : cfg_round;
    sz = (r.req_size == 0) ? 1 : r.req_size;
    sz = (sz + rr - 1) / rr * rr;
    st = ST_OK;
    blk = '0;
    found = 0;
    best = 0;
    case (r.func)
      FUNC_BEST: begin
        if (longint'(free_left) < sz) st = ST_NOFIT;
        else begin
          for (i = 0; i < ext_cnt; i++)
            if (ext_len[i] >= sz && (!found || ext_len[i] < ext_len[best])) begin
              best = i;
              found = 1;
            end
          if (!found) st = ST_NOFIT;
          else begin
            blk = ext_start[best];
            if (ext_len[best] == sz) ext_remove(best);
            else begin
              ext_start[best] = ext_start[best] + sz[31:0];
              ext_len[best]   = ext_len[best] - sz[31:0];
            end
            free_left = free_left - sz[31:0];
          end
        end
      end
      FUNC_AT: begin
        he = longint'(r.addr) + sz;
        for (i = 0; i < ext_cnt; i++) begin
          s = ext_start[i];
          e = s + ext_len[i];
          if (r.addr >= s && he <= e) break;
        end
        if (i == ext_cnt) st = ST_HINT;
        else begin
          s = ext_start[i];
          e = s + ext_len[i];
          if (r.addr == s && he == e) ext_remove(i);
          else if (r.addr == s) begin
            ext_start[i] = he[31:0];
            ext_len[i]   = 32'(e - he);
          end else if (he == e) ext_len[i] = 32'(r.addr - s);
          else if (ext_cnt >= NEXT) st = ST_FULL;
          else begin
            ext_len[i] = 32'(r.addr - s);
            ext_insert(i + 1, he[31:0], 32'(e - he));
          end
          if (st == ST_OK) begin
            free_left = free_left - sz[31:0];
            blk = r.addr;
          end
        end
      end
      FUNC_FREE: begin
        rend = longint'(cfg_base) + cfg_size;
        a = r.addr;
        if (a < cfg_base || a >= rend) st = ST_OUTSIDE;
        else begin
          e = a + sz;
          if (e > rend) e = rend;
          pos = 0;
          while (pos < ext_cnt && ext_start[pos] < a) pos++;
          jp = 0;
          jn = 0;
          if (pos > 0) begin
            pe = longint'(ext_start[pos-1]) + ext_len[pos-1];
            if (pe > a) st = ST_OUTSIDE;
            jp = (pe == a);
          end
          if (st == ST_OK && pos < ext_cnt) begin
            if (ext_start[pos] < e) st = ST_OUTSIDE;
            jn = (ext_start[pos] == e);
          end
          if (st == ST_OK) begin
            if (jp && jn) begin
              ext_len[pos-1] = ext_len[pos-1] + 32'(e - a) + ext_len[pos];
              ext_remove(pos);
            end else if (jp) ext_len[pos-1] = ext_len[pos-1] + 32'(e - a);
            else if (jn) begin
              ext_start[pos] = r.addr;
              ext_len[pos]   = ext_len[pos] + 32'(e - a);
            end else if (ext_cnt >= NEXT) st = ST_FULL;
            else ext_insert(pos, r.addr, 32'(e - a));
            if (st == ST_OK) free_left = free_left + 32'(e - a);
          end
        end
      end
      default: ;
    endcase
    if (st != ST_OK) blk = '0;
    o.block_addr = blk;
    o.status     = st;
    o.free_bytes = free_left;
    return o;
  endfunction

  // Predict at acceptance; track live allocations for well-formed frees.
  always @(posedge clk_i) begin
    rsp_t p;
    if (rst_ni && start && !busy) begin
      p = alloc_predict(req_i);
      if (p.status == ST_OK && req_i.func inside {FUNC_BEST, FUNC_AT})
        held_q.push_back('{p.block_addr, req_i.req_size});
      rsp_q.push_back(typed_pending ? typed_rsp : p);
      accept_cnt++;
      wdog = 0;
    end
    if (rst_ni && done_o) begin
      wdog = 0;
      result_cnt++;
      status_cnt[result_o.status]++;
      if (rsp_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result %p", result_o);
      end else begin
        p = rsp_q.pop_front();
        if (p.block_addr !== result_o.block_addr || p.status !== result_o.status ||
            p.free_bytes !== result_o.free_bytes) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: exp addr %h st %0d free %h, got addr %h st %0d free %h",
                     p.block_addr, p.status, p.free_bytes,
                     result_o.block_addr, result_o.status, result_o.free_bytes);
        end
      end
    end
    if (rst_ni && !(start && !busy) && !done_o) begin
      wdog++;
      if (wdog >= WDOG_MAX) begin
        $display("best_fit_extent_allocator test failed");
        $finish;
      end
    end
  end

  task automatic send(req_t r, logic is_typed, rsp_t t, int idle_pct);
    int n0;
    if ($urandom_range(99) < idle_pct) repeat ($urandom_range(1, 6)) @(negedge clk_i);
    req_i = r;
    typed_pending = is_typed;
    typed_rsp = t;
    start = 1'b1;
    n0 = accept_cnt;
    do @(negedge clk_i); while (accept_cnt == n0);
    start = 1'b0;
    typed_pending = 1'b0;
  endtask

  task automatic drain();
    while (rsp_q.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      REG_BASE:  cfg_base = val;
      REG_SIZE:  cfg_size = val;
      default:   cfg_round = val[8:0];
    endcase
    table_init();
    held_q.delete();
  endtask

  task automatic configure(logic [31:0] b, logic [31:0] s, logic [8:0] rnd);
    drain();
    reg_write(REG_BASE, b);
    reg_write(REG_SIZE, s);
    reg_write(REG_ROUND, {23'd0, rnd});
  endtask

  // Mostly well-formed traffic: live blocks freed, hints inside the region.
  task automatic random_run(int n, int idle_pct);
    req_t  r;
    rsp_t  none;
    held_t h;
    int    k, sel;
    none = '0;
    for (int it = 0; it < n; it++) begin
      if (it == n / 2) while (rsp_q.size() != 0) @(negedge clk_i);
      sel = $urandom_range(99);
      r.req_size = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 40);
      r.addr = cfg_base + ((cfg_size == 0) ? 0 : $urandom % cfg_size);
      if (sel < 35) r.func = FUNC_BEST;
      else if (sel < 60) begin
        r.func = FUNC_AT;
        if (held_q.size() != 0 && $urandom_range(3) == 0)
          r.addr = held_q[$urandom_range(held_q.size() - 1)].addr;
      end else if (sel < 90) begin
        r.func = FUNC_FREE;
        if (held_q.size() != 0 && $urandom_range(4) != 0) begin
          k = $urandom_range(held_q.size() - 1);
          h = held_q[k];
          held_q.delete(k);
          r.addr = h.addr;
          r.req_size = h.len;
        end
      end else begin
        r.func = 2'($urandom_range(3));
        r.req_size = $urandom;
        r.addr = $urandom;
      end
      send(r, 1'b0, none, (it % 100 < 20) ? 0 : idle_pct);
    end
  endtask

  initial begin
    req_t r;
    rsp_t t;
    table_init();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    for (int k = 0; k < 14; k++) begin
      r.func = dir_tab[k].func;
      r.req_size = dir_tab[k].req_size;
      r.addr = dir_tab[k].addr;
      t.block_addr = dir_tab[k].e_addr;
      t.status = dir_tab[k].e_status;
      t.free_bytes = dir_tab[k].e_free;
      send(r, dir_tab[k].typed, t, 0);
    end
    random_run(180, 0);
    configure(32'hFFFFF000, 32'd1000, 9'd1);
    random_run(180, 61);
    configure(32'h0, 32'h0, 9'd8);
    random_run(30, 0);
    configure(32'h80000000, 32'hFFFFFFFF, 9'd256);
    random_run(180, 6);
    configure(32'd100, 32'd512, 9'd0);
    random_run(250, 61);
    configure(RST_BASE, RST_SIZE, RST_ROUND);
    random_run(180, 0);
    drain();
    $display("Covered %0d requests and %0d results over six region settings.",
             accept_cnt, result_cnt);
    $display("Statuses seen: ok %0d, no fit %0d, outside %0d, full %0d, hint %0d.",
             status_cnt[0], status_cnt[1], status_cnt[2], status_cnt[3], status_cnt[4]);
    if (err_cnt == 0 && rsp_q.size() == 0) begin
      $display("best_fit_extent_allocator test passed");
    end else begin
      $display("best_fit_extent_allocator test failed");
    end
    $finish;
  end

endmodule
